// ===== rtl/phong_point_spot_shader_defines.svh =====
// Assertion macros shared by the shader RTL.
`ifndef PHONG_POINT_SPOT_SHADER_DEFINES_SVH
`define PHONG_POINT_SPOT_SHADER_DEFINES_SVH
`ifndef SYNTHESIS
`define PPS_ASSERT_IMPL(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("shader check failed");
`define PPS_ASSERT_NEXT(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("shader check failed");
`else
`define PPS_ASSERT_IMPL(name, pre, post)
`define PPS_ASSERT_NEXT(name, pre, post)
`endif
`endif

// ===== rtl/pps_pkg.sv =====
// Types, constants and helpers shared by the shader RTL.
package pps_pkg;

	localparam int COORD_W = 20;
	localparam int DIFF_W = 21;
	localparam int Q14_W = 16;
	localparam int CHAN_W = 16;
	localparam int SUM_W = 44;
	localparam int LEN_W = 21;
	localparam int MAG_W = 20;
	localparam int REM_W = 36;
	localparam int SQRT_STEPS = 22;
	localparam int DIV_STEPS = 15;
	localparam int NORM_LAT = SQRT_STEPS + DIV_STEPS + 4;
	localparam int LDN_W = 18;
	localparam int R_W = 21;
	localparam int RDV_W = 23;
	localparam int BASE_W = 22;
	localparam int ACC_W = 21;
	localparam int SHINE_STEPS = 255;
	localparam int LIGHT_LAT = SHINE_STEPS + 8;

	localparam logic [ACC_W-1:0] ONE_Q14 = 21'd16384;
	localparam logic [ACC_W-1:0] SPEC_CAP = 21'd1048576;
	localparam logic [13:0] AMBIENT_Q14 = 14'd3277;

	typedef logic signed [Q14_W-1:0] q14_t;
	typedef logic signed [DIFF_W-1:0] diff_t;
	typedef logic signed [COORD_W-1:0] coord_t;

	typedef struct packed {
		logic       enable;
		logic [7:0] shininess;
	} spec_cfg_t;

	typedef enum logic [2:0] {
		REG_OBJECT_COLOR    = 3'd0,
		REG_SPECULAR_ENABLE = 3'd1,
		REG_SHININESS       = 3'd2,
		REG_LIGHT_POSITION  = 3'd3,
		REG_SPOT_POSITION   = 3'd4,
		REG_SPOT_DIRECTION  = 3'd5,
		REG_SPOT_CUTOFF_COS = 3'd6,
		REG_SPOT_ENABLE     = 3'd7
	} cfg_reg_t;

	// Arithmetic shift right with rounding to nearest, ties away from zero.
	function automatic logic signed [47:0] round_shift(input logic signed [47:0] v,
		input int unsigned sh);
		logic signed [47:0] half;
		half = 48'sd1 <<< (sh - 1);
		if (v >= 0) begin
			round_shift = (v + half) >>> sh;
		end else begin
			round_shift = -((-v + half) >>> sh);
		end
	endfunction

endpackage

// ===== rtl/pps_norm.sv =====
// Pipelined vector normalizer: integer square root then restoring division.
module pps_norm
	import pps_pkg::*;
(
	input  logic  clk,
	input  logic  en,
	input  diff_t d [3],
	output q14_t  u [3]
);

	logic [2*DIFF_W-1:0] sq_s1 [3];
	diff_t d_s1 [3];

	logic [SUM_W-1:0] rem_sq [SQRT_STEPS+1];
	logic [SUM_W-1:0] root_sq [SQRT_STEPS+1];
	logic [MAG_W-1:0] mag_sq [SQRT_STEPS+1][3];
	logic neg_sq [SQRT_STEPS+1][3];

	logic [REM_W-1:0] rem_dv [DIV_STEPS+1][3];
	logic [DIV_STEPS-1:0] quo_dv [DIV_STEPS+1][3];
	logic [LEN_W-1:0] len_dv [DIV_STEPS+1];
	logic neg_dv [DIV_STEPS+1][3];

	q14_t u_next [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sq_s1[i] <= (2*DIFF_W)'(d[i]) * (2*DIFF_W)'(d[i]);
				d_s1[i] <= d[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_sq[0] <= SUM_W'(sq_s1[0]) + SUM_W'(sq_s1[1]) + SUM_W'(sq_s1[2]);
			root_sq[0] <= '0;
			for (int i = 0; i < 3; i++) begin
				mag_sq[0][i] <= (d_s1[i] < 0) ? MAG_W'(-d_s1[i]) : MAG_W'(d_s1[i]);
				neg_sq[0][i] <= d_s1[i] < 0;
			end
		end
	end

	// One result bit per stage, highest bit first.
	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
		localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (2 * (SQRT_STEPS - 1 - k));
		logic [SUM_W-1:0] trial;
		assign trial = root_sq[k] + BIT;
		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_sq[k] >= trial) begin
					rem_sq[k+1] <= rem_sq[k] - trial;
					root_sq[k+1] <= (root_sq[k] >> 1) + BIT;
				end else begin
					rem_sq[k+1] <= rem_sq[k];
					root_sq[k+1] <= root_sq[k] >> 1;
				end
				mag_sq[k+1] <= mag_sq[k];
				neg_sq[k+1] <= neg_sq[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			len_dv[0] <= LEN_W'(root_sq[SQRT_STEPS]);
			for (int i = 0; i < 3; i++) begin
				rem_dv[0][i] <= REM_W'(mag_sq[SQRT_STEPS][i]) << 14;
				quo_dv[0][i] <= '0;
				neg_dv[0][i] <= neg_sq[SQRT_STEPS][i];
			end
		end
	end

	// The magnitude never exceeds the length, so the quotient fits in fifteen bits.
	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
		localparam int SH = DIV_STEPS - 1 - j;
		logic [REM_W-1:0] dvs;
		assign dvs = REM_W'(len_dv[j]) << SH;
		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < 3; i++) begin
					if (rem_dv[j][i] >= dvs) begin
						rem_dv[j+1][i] <= rem_dv[j][i] - dvs;
						quo_dv[j+1][i] <= {quo_dv[j][i][DIV_STEPS-2:0], 1'b1};
					end else begin
						rem_dv[j+1][i] <= rem_dv[j][i];
						quo_dv[j+1][i] <= {quo_dv[j][i][DIV_STEPS-2:0], 1'b0};
					end
				end
				len_dv[j+1] <= len_dv[j];
				neg_dv[j+1] <= neg_dv[j];
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (len_dv[DIV_STEPS] == '0) begin
				u_next[i] = '0;
			end else if (neg_dv[DIV_STEPS][i]) begin
				u_next[i] = -q14_t'(quo_dv[DIV_STEPS][i]);
			end else begin
				u_next[i] = q14_t'(quo_dv[DIV_STEPS][i]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			u <= u_next;
		end
	end

endmodule

// ===== rtl/pps_light.sv =====
// Per-light shading pipeline: diffuse dot product, reflection and specular power.
module pps_light
	import pps_pkg::*;
(
	input  logic                    clk,
	input  logic                    en,
	input  spec_cfg_t               cfg,
	input  q14_t                    l [3],
	input  q14_t                    n [3],
	input  q14_t                    v [3],
	output logic signed [LDN_W-1:0] diff,
	output logic [ACC_W-1:0]        spec
);

	logic signed [31:0] ln_s1 [3];
	q14_t l_s1 [3], n_s1 [3], v_s1 [3];
	logic signed [LDN_W-1:0] ldn_s2;
	q14_t l_s2 [3], n_s2 [3], v_s2 [3];
	logic signed [34:0] m_s3 [3];
	logic signed [LDN_W-1:0] ldn_s3;
	q14_t l_s3 [3], v_s3 [3];
	logic signed [R_W-1:0] r_s4 [3];
	logic signed [LDN_W-1:0] ldn_s4;
	q14_t v_s4 [3];
	logic signed [36:0] rv_s5 [3];
	logic signed [LDN_W-1:0] ldn_s5;
	logic signed [RDV_W-1:0] rdv_s6;
	logic signed [LDN_W-1:0] ldn_s6;

	logic [ACC_W-1:0] acc_pw [SHINE_STEPS+1];
	logic [BASE_W-1:0] base_pw [SHINE_STEPS+1];
	logic pos_pw [SHINE_STEPS+1];
	logic signed [LDN_W-1:0] ldn_pw [SHINE_STEPS+1];

	logic signed [33:0] ln_sum;
	logic signed [38:0] rv_sum;
	logic signed [R_W-1:0] r_next [3];

	always_comb begin
		ln_sum = 34'(ln_s1[0]) + 34'(ln_s1[1]) + 34'(ln_s1[2]);
		rv_sum = 39'(rv_s5[0]) + 39'(rv_s5[1]) + 39'(rv_s5[2]);
		for (int i = 0; i < 3; i++) begin
			r_next[i] = R_W'(round_shift(48'(m_s3[i]), 14)) - R_W'(l_s3[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				ln_s1[i] <= 32'(l[i]) * 32'(n[i]);
				m_s3[i] <= (35'(ldn_s2) * 35'(n_s2[i])) <<< 1;
				r_s4[i] <= r_next[i];
				rv_s5[i] <= 37'(r_s4[i]) * 37'(v_s4[i]);
			end
			l_s1 <= l;
			n_s1 <= n;
			v_s1 <= v;
			ldn_s2 <= LDN_W'(round_shift(48'(ln_sum), 14));
			l_s2 <= l_s1;
			n_s2 <= n_s1;
			v_s2 <= v_s1;
			ldn_s3 <= ldn_s2;
			l_s3 <= l_s2;
			v_s3 <= v_s2;
			ldn_s4 <= ldn_s3;
			v_s4 <= v_s3;
			ldn_s5 <= ldn_s4;
			rdv_s6 <= RDV_W'(round_shift(48'(rv_sum), 14));
			ldn_s6 <= ldn_s5;
			acc_pw[0] <= ONE_Q14;
			pos_pw[0] <= rdv_s6 > 0;
			base_pw[0] <= (rdv_s6 > 0) ? BASE_W'(rdv_s6) : '0;
			ldn_pw[0] <= ldn_s6;
		end
	end

	// Stage k applies the k-th multiply only while k is below the exponent.
	for (genvar k = 0; k < SHINE_STEPS; k++) begin : g_pow
		logic [ACC_W+BASE_W-1:0] prod;
		logic [ACC_W+BASE_W-1:0] rnd;
		assign prod = (ACC_W + BASE_W)'(acc_pw[k]) * (ACC_W + BASE_W)'(base_pw[k]);
		assign rnd = (prod + (ACC_W + BASE_W)'(8192)) >> 14;
		always_ff @(posedge clk) begin
			if (en) begin
				if (cfg.shininess > 8'(k)) begin
					acc_pw[k+1] <= (rnd > (ACC_W + BASE_W)'(SPEC_CAP)) ? SPEC_CAP
						: ACC_W'(rnd);
				end else begin
					acc_pw[k+1] <= acc_pw[k];
				end
				base_pw[k+1] <= base_pw[k];
				pos_pw[k+1] <= pos_pw[k];
				ldn_pw[k+1] <= ldn_pw[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			diff <= ldn_pw[SHINE_STEPS];
			spec <= (cfg.enable && pos_pw[SHINE_STEPS]) ? acc_pw[SHINE_STEPS] : '0;
		end
	end

endmodule

// ===== rtl/phong_point_spot_shader.sv =====
// Top level of the Phong shader with a point light and an optional spotlight.
// One word is accepted every cycle; the whole pipeline advances together and
// holds only while a finished output word waits on out_ready.
// The 255-stage specular power chain in each light unit sets most of the latency.
// Reset clears valid bits and settings (cutoff to 1.0); datapath is not reset.
`include "phong_point_spot_shader_defines.svh"

module phong_point_spot_shader
	import pps_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [19:0] hit_x,
	input  logic signed [19:0] hit_y,
	input  logic signed [19:0] hit_z,
	input  logic signed [15:0] normal_x,
	input  logic signed [15:0] normal_y,
	input  logic signed [15:0] normal_z,
	input  logic signed [15:0] view_x,
	input  logic signed [15:0] view_y,
	input  logic signed [15:0] view_z,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] red,
	output logic signed [15:0] green,
	output logic signed [15:0] blue,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [59:0]        cfg_data
);

	localparam int LIGHT_OUT = NORM_LAT + LIGHT_LAT;
	localparam int VLD_N = LIGHT_OUT + 2;

	logic [47:0] color_q;
	logic spec_en_q;
	logic [7:0] shine_q;
	logic [59:0] light_pos_q;
	logic [59:0] spot_pos_q;
	logic [59:0] spot_dir_q;
	logic signed [15:0] cutoff_q;
	logic spot_en_q;

	logic adv;
	logic vld_q [VLD_N];
	logic out_valid_q;
	logic signed [15:0] res_q [3];

	coord_t hit [3], lp [3], sp [3], sd [3];
	q14_t nrm [3], vw [3];
	diff_t d1_s1 [3], d2_s1 [3], ax_s1 [3];
	q14_t n_s1 [3], v_s1 [3];
	q14_t n_dly [NORM_LAT][3];
	q14_t v_dly [NORM_LAT][3];
	q14_t l1 [3], l2 [3], dn [3], n_al [3], v_al [3];

	logic signed [31:0] cone_prod_s2 [3];
	logic signed [33:0] cone_sum;
	logic cone_in;
	logic two_dly [LIGHT_LAT-1];

	spec_cfg_t spec_cfg;
	logic signed [LDN_W-1:0] diff1, diff2;
	logic [ACC_W-1:0] spec1, spec2;

	logic [CHAN_W-1:0] chan [3];
	logic signed [34:0] cd1_s3 [3], cd2_s3 [3];
	logic [27:0] amb_s3 [3];
	logic [ACC_W-1:0] spec1_s3, spec2_s3;
	logic two_s3;
	logic signed [39:0] sum_c [3];
	logic signed [47:0] rq [3];
	logic signed [15:0] sat [3];

	assign adv = !out_valid_q || out_ready;
	assign in_ready = adv;
	assign out_valid = out_valid_q;
	assign red = res_q[0];
	assign green = res_q[1];
	assign blue = res_q[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q <= '0;
			spec_en_q <= 1'b0;
			shine_q <= '0;
			light_pos_q <= '0;
			spot_pos_q <= '0;
			spot_dir_q <= '0;
			cutoff_q <= 16'sd16384;
			spot_en_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_OBJECT_COLOR: color_q <= cfg_data[47:0];
				REG_SPECULAR_ENABLE: spec_en_q <= cfg_data[0];
				REG_SHININESS: shine_q <= cfg_data[7:0];
				REG_LIGHT_POSITION: light_pos_q <= cfg_data;
				REG_SPOT_POSITION: spot_pos_q <= cfg_data;
				REG_SPOT_DIRECTION: spot_dir_q <= cfg_data;
				REG_SPOT_CUTOFF_COS: cutoff_q <= cfg_data[15:0];
				REG_SPOT_ENABLE: spot_en_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		hit[0] = hit_x;
		hit[1] = hit_y;
		hit[2] = hit_z;
		nrm[0] = normal_x;
		nrm[1] = normal_y;
		nrm[2] = normal_z;
		vw[0] = view_x;
		vw[1] = view_y;
		vw[2] = view_z;
		for (int i = 0; i < 3; i++) begin
			lp[i] = light_pos_q[COORD_W*(3-i)-1 -: COORD_W];
			sp[i] = spot_pos_q[COORD_W*(3-i)-1 -: COORD_W];
			sd[i] = spot_dir_q[COORD_W*(3-i)-1 -: COORD_W];
			chan[i] = color_q[CHAN_W*(3-i)-1 -: CHAN_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < VLD_N; k++) begin
				vld_q[k] <= 1'b0;
			end
			out_valid_q <= 1'b0;
		end else if (adv) begin
			vld_q[0] <= in_valid;
			for (int k = 1; k < VLD_N; k++) begin
				vld_q[k] <= vld_q[k-1];
			end
			out_valid_q <= vld_q[VLD_N-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				d1_s1[i] <= diff_t'(lp[i]) - diff_t'(hit[i]);
				d2_s1[i] <= diff_t'(sp[i]) - diff_t'(hit[i]);
				ax_s1[i] <= diff_t'(sd[i]);
			end
			n_s1 <= nrm;
			v_s1 <= vw;
			n_dly[0] <= n_s1;
			v_dly[0] <= v_s1;
			for (int k = 1; k < NORM_LAT; k++) begin
				n_dly[k] <= n_dly[k-1];
				v_dly[k] <= v_dly[k-1];
			end
		end
	end

	pps_norm u_norm_light (.clk(clk), .en(adv), .d(d1_s1), .u(l1));
	pps_norm u_norm_spot  (.clk(clk), .en(adv), .d(d2_s1), .u(l2));
	pps_norm u_norm_axis  (.clk(clk), .en(adv), .d(ax_s1), .u(dn));

	always_comb begin
		n_al = n_dly[NORM_LAT-1];
		v_al = v_dly[NORM_LAT-1];
		spec_cfg.enable = spec_en_q;
		spec_cfg.shininess = shine_q;
		cone_sum = 34'(cone_prod_s2[0]) + 34'(cone_prod_s2[1]) + 34'(cone_prod_s2[2]);
		cone_in = spot_en_q && (round_shift(48'(cone_sum), 14) >= 48'(cutoff_q));
	end

	// The cone flag waits beside the light units so it lands with their results.
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				cone_prod_s2[i] <= -(32'(l2[i]) * 32'(dn[i]));
			end
			two_dly[0] <= cone_in;
			for (int k = 1; k < LIGHT_LAT-1; k++) begin
				two_dly[k] <= two_dly[k-1];
			end
		end
	end

	pps_light u_light_point (
		.clk(clk), .en(adv), .cfg(spec_cfg), .l(l1), .n(n_al), .v(v_al),
		.diff(diff1), .spec(spec1)
	);

	pps_light u_light_spot (
		.clk(clk), .en(adv), .cfg(spec_cfg), .l(l2), .n(n_al), .v(v_al),
		.diff(diff2), .spec(spec2)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				cd1_s3[i] <= 35'($signed({1'b0, chan[i]})) * 35'(diff1);
				cd2_s3[i] <= 35'($signed({1'b0, chan[i]})) * 35'(diff2);
				amb_s3[i] <= 28'(chan[i]) * 28'(AMBIENT_Q14);
			end
			spec1_s3 <= spec1;
			spec2_s3 <= spec2;
			two_s3 <= two_dly[LIGHT_LAT-2];
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sum_c[i] = 40'($signed({1'b0, amb_s3[i]})) + 40'(cd1_s3[i])
				+ (40'($signed({1'b0, spec1_s3})) <<< 15);
			if (two_s3) begin
				sum_c[i] = sum_c[i] + 40'(cd2_s3[i])
					+ (40'($signed({1'b0, spec2_s3})) <<< 15);
			end
			rq[i] = round_shift(48'(sum_c[i]), 17);
			if (rq[i] > 48'sd32767) begin
				sat[i] = 16'sh7FFF;
			end else if (rq[i] < -48'sd32768) begin
				sat[i] = 16'sh8000;
			end else begin
				sat[i] = 16'(rq[i]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= sat;
		end
	end

	`PPS_ASSERT_NEXT(a_accept_enters, in_valid && in_ready, vld_q[0])
	`PPS_ASSERT_IMPL(a_no_cone_when_off, vld_q[LIGHT_OUT] && !spot_en_q, !two_dly[LIGHT_LAT-2])
	`PPS_ASSERT_IMPL(a_spec_off, vld_q[LIGHT_OUT] && !spec_en_q, spec1 == '0 && spec2 == '0)
	`PPS_ASSERT_IMPL(a_spec_cap, vld_q[LIGHT_OUT], spec1 <= SPEC_CAP && spec2 <= SPEC_CAP)

endmodule
